/* rtl/core/hqp_pkg.sv */
package hqp_pkg;

	localparam int unsigned SIZE_W = 15;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 15'd16381;

	localparam int unsigned OUTCOME_W = 2;
	localparam int unsigned SLOT_W    = 14;
	localparam int unsigned COUNT_W   = 15;
	localparam int unsigned RESULT_W  = OUTCOME_W + SLOT_W + COUNT_W;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_FOUND     = 2'd0,
		OUT_EMPTY     = 2'd1,
		OUT_EXHAUSTED = 2'd2
	} outcome_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SEARCH = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK
	} back_state_t;

	typedef struct packed {
		logic [COUNT_W-1:0]   probe_count;
		logic [SLOT_W-1:0]    slot;
		outcome_t             outcome;
	} result_t;

endpackage

/* rtl/core/hqp_ram.sv */
module hqp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/hqp_front.sv */
module hqp_front #(
	parameter int unsigned KEY_BITS = 20,
	parameter int unsigned SZW      = 15,
	parameter int unsigned AW       = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SZW-1:0]      size,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_op,
	input  logic [KEY_BITS-1:0] in_key,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_op,
	output logic [KEY_BITS-1:0] out_key,
	output logic [AW-1:0]       out_home
);

	localparam int unsigned CNW = $clog2(KEY_BITS + 1);

	logic                busy_q;
	logic                hold_q;
	logic [CNW-1:0]      cnt_q;
	logic                op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] shift_q;
	logic [SZW-1:0]      rem_q;
	logic [SZW:0]        trial;
	logic [SZW-1:0]      rem_next;

	assign in_ready = !busy_q && !hold_q;

	// one quotient bit per cycle, msb first
	always_comb begin
		trial = {rem_q, shift_q[KEY_BITS-1]};
		if (trial >= {1'b0, size}) begin
			rem_next = SZW'(trial - {1'b0, size});
		end else begin
			rem_next = SZW'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			hold_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(KEY_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					hold_q <= 1'b1;
				end
			end else if (hold_q && out_ready) begin
				hold_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= in_op;
			key_q   <= in_key;
			shift_q <= in_key;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= shift_q << 1;
			rem_q   <= rem_next;
		end
	end

	assign out_valid = hold_q;
	assign out_op    = op_q;
	assign out_key   = key_q;
	assign out_home  = AW'(rem_q);

endmodule

/* rtl/core/hqp_queue.sv */
module hqp_queue #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         push;
	logic         pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

/* rtl/core/hqp_back.sv */
module hqp_back #(
	parameter int unsigned TABLE_DEPTH = 16384,
	parameter int unsigned KEY_BITS    = 20,
	parameter int unsigned SZW         = 15,
	parameter int unsigned AW          = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SZW-1:0]      size,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_op,
	input  logic [KEY_BITS-1:0] in_key,
	input  logic [AW-1:0]       in_home,
	output logic                out_valid,
	input  logic                out_ready,
	output hqp_pkg::result_t    out_result
);

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 2);
	localparam int unsigned DW = KEY_BITS + 1;

	hqp_pkg::back_state_t state_q, state_d;

	logic [AW-1:0]       clr_q;
	logic                op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [AW-1:0]       pos_q;
	logic [SZW-1:0]      step_q;
	logic [CW-1:0]       i_q;
	logic                out_valid_q;
	hqp_pkg::result_t    result_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [DW-1:0]       ram_wdata;
	logic                ram_re;
	logic [DW-1:0]       ram_rdata;

	logic                slot_empty;
	logic                slot_match;
	logic                last_probe;
	logic                finish;
	logic                out_free;
	logic                pop;
	logic                advance;
	logic                emit;
	logic [SZW:0]        pos_sum;
	logic [SZW:0]        step_sum;
	logic [AW-1:0]       pos_next;
	logic [SZW-1:0]      step_next;
	hqp_pkg::result_t    result_d;

	hqp_ram #(
		.WIDTH (DW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	assign slot_empty = !ram_rdata[KEY_BITS];
	assign slot_match = (ram_rdata[KEY_BITS-1:0] == key_q);
	assign last_probe = (i_q == CW'(size));
	assign finish     = slot_empty || slot_match || last_probe;
	assign out_free   = !out_valid_q || out_ready;

	// (home + i*i) mod size, stepping by the odd numbers
	always_comb begin
		pos_sum  = (SZW+1)'(pos_q) + (SZW+1)'(step_q);
		step_sum = (SZW+1)'(step_q) + (SZW+1)'(2);
		if (pos_sum >= (SZW+1)'(size)) begin
			pos_next = AW'(pos_sum - (SZW+1)'(size));
		end else begin
			pos_next = AW'(pos_sum);
		end
		if (step_sum >= (SZW+1)'(size)) begin
			step_next = SZW'(step_sum - (SZW+1)'(size));
		end else begin
			step_next = SZW'(step_sum);
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = {1'b1, key_q};
		ram_re    = 1'b0;
		advance   = 1'b0;
		emit      = 1'b0;
		result_d  = result_q;
		unique case (state_q)
			hqp_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == AW'(TABLE_DEPTH - 1)) begin
					state_d = hqp_pkg::ST_IDLE;
				end
			end
			hqp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = hqp_pkg::ST_READ;
				end
			end
			hqp_pkg::ST_READ: begin
				ram_re  = 1'b1;
				state_d = hqp_pkg::ST_CHECK;
			end
			hqp_pkg::ST_CHECK: begin
				if (!finish) begin
					advance = 1'b1;
					state_d = hqp_pkg::ST_READ;
				end else if (out_free) begin
					emit = 1'b1;
					state_d = hqp_pkg::ST_IDLE;
					if (slot_empty) begin
						result_d.outcome = hqp_pkg::OUT_EMPTY;
						result_d.slot    = hqp_pkg::SLOT_W'(pos_q);
						result_d.probe_count = hqp_pkg::COUNT_W'(i_q);
						ram_we = (op_q == hqp_pkg::OP_INSERT);
					end else if (slot_match) begin
						result_d.outcome = hqp_pkg::OUT_FOUND;
						result_d.slot    = hqp_pkg::SLOT_W'(pos_q);
						result_d.probe_count = hqp_pkg::COUNT_W'(i_q);
					end else begin
						result_d.outcome = hqp_pkg::OUT_EXHAUSTED;
						result_d.slot    = '0;
						result_d.probe_count = hqp_pkg::COUNT_W'(i_q + 1'b1);
					end
				end
			end
			default: begin
				state_d = hqp_pkg::ST_CLEAR;
			end
		endcase
	end

	assign pop = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hqp_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == hqp_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q   <= in_op;
			key_q  <= in_key;
			pos_q  <= in_home;
			step_q <= SZW'(1);
			i_q    <= CW'(1);
		end else if (advance) begin
			pos_q  <= pos_next;
			step_q <= step_next;
			i_q    <= i_q + 1'b1;
		end
		if (emit) begin
			result_q <= result_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = result_q;

`ifndef ASSERT_OFF
	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hqp_pkg::ST_CLEAR) |-> !pop)
		else $error("request taken during clearing pass");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == hqp_pkg::ST_CLEAR || state_q == hqp_pkg::ST_CHECK))
		else $error("table write outside clear or check");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hqp_pkg::ST_READ) |-> ((SZW+1)'(pos_q) < (SZW+1)'(size)))
		else $error("probe position beyond table size");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hqp_pkg::ST_CHECK) |-> (i_q <= CW'(size)))
		else $error("probe counter beyond table size");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("result lost");
`endif

endmodule

/* rtl/core/hash_table_quadratic_probe_unit.sv */
// Open-addressed hash table with quadratic probing: each request inserts or
// searches a key; the home slot is key mod table_size and probe i visits
// (home + i*i) mod table_size. After reset the unit sweeps the whole table
// once to clear it and starts probing only after that (requests are still
// taken into the front queue). The front holds one request at a time: it
// accepts it, reduces the key modulo table_size bit-serially and then hands
// it to the queue, waiting there while the queue is full. The back picks a
// request in its idle state, then for each probe reads the table in its
// read state and compares in its check state, as the table memory has a
// registered read port; a finished request waits there until the result
// register is free. Front and back overlap through a two-entry queue.
// table_size must be written only while the unit is idle; the unit does not
// enforce it. Values below 2 act as 2, values above TABLE_DEPTH as TABLE_DEPTH.
module hash_table_quadratic_probe_unit #(
	parameter int unsigned TABLE_DEPTH = 16384,
	parameter int unsigned KEY_BITS    = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // opcode, key
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // outcome, slot, probe_count
);

	localparam int unsigned SZW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned AW  = $clog2(TABLE_DEPTH);
	localparam int unsigned QW  = 1 + KEY_BITS + AW;

	logic [hqp_pkg::SIZE_W-1:0] table_size_q;
	logic [SZW-1:0]             size;
	logic [KEY_BITS-1:0]        in_key;

	logic                f_valid;
	logic                f_ready;
	logic                f_op;
	logic [KEY_BITS-1:0] f_key;
	logic [AW-1:0]       f_home;
	logic                b_valid;
	logic                b_ready;
	logic [QW-1:0]       b_data;
	hqp_pkg::result_t    result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= hqp_pkg::SIZE_RESET;
		end else if (cfg_valid) begin
			table_size_q <= cfg_data;
		end
	end

	always_comb begin
		if (32'(table_size_q) < 32'd2) begin
			size = SZW'(2);
		end else if (32'(table_size_q) > 32'(TABLE_DEPTH)) begin
			size = SZW'(TABLE_DEPTH);
		end else begin
			size = SZW'(table_size_q);
		end
	end

	assign in_key = KEY_BITS'(s_tdata[20:1]);

	hqp_front #(
		.KEY_BITS (KEY_BITS),
		.SZW      (SZW),
		.AW       (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.size      (size),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tdata[0]),
		.in_key    (in_key),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_op    (f_op),
		.out_key   (f_key),
		.out_home  (f_home)
	);

	hqp_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   ({f_home, f_key, f_op}),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (b_data)
	);

	hqp_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS),
		.SZW         (SZW),
		.AW          (AW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.size       (size),
		.in_valid   (b_valid),
		.in_ready   (b_ready),
		.in_op      (b_data[0]),
		.in_key     (b_data[KEY_BITS:1]),
		.in_home    (b_data[QW-1:KEY_BITS+1]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata = {1'b0, result.probe_count, result.slot, result.outcome};

endmodule

/* sim/tb_top.sv */
module tb_top;

	localparam int unsigned DEPTH = 16384;
	localparam int unsigned CYCLE_LIMIT = 4000000;
	localparam int unsigned ITEM_GOAL = 1750;

	class probe_scoreboard;
		bit [19:0]          slot_key [DEPTH];
		bit                 slot_used [DEPTH];
		int unsigned        size_reg;
		hqp_pkg::result_t   pending_q [$];
		int unsigned errors, checked, n_found, n_empty, n_exhausted;

		function new();
			size_reg = hqp_pkg::SIZE_RESET;
			foreach (slot_used[i]) slot_used[i] = 1'b0;
		endfunction

		function void set_size(logic [hqp_pkg::SIZE_W-1:0] v);
			size_reg = v;
		endfunction

		function int unsigned pending();
			return pending_q.size();
		endfunction

		function void report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endfunction

		// probe sequence for one request, updating the table on insert
		function void note(hqp_pkg::opcode_t op, bit [19:0] key);
			int unsigned sz, home, pos, i, cnt;
			hqp_pkg::result_t r;
			sz = size_reg;
			if (sz < 2) sz = 2;
			if (sz > DEPTH) sz = DEPTH;
			home = key % sz;
			pos = home;
			i = 1;
			cnt = 1;
			while (i < sz + 1) begin
				if (!slot_used[pos]) break;
				if (slot_key[pos] == key) break;
				pos = (home + i * i) % sz;
				cnt++;
				i++;
			end
			if (i >= sz + 1) begin
				r.outcome = hqp_pkg::OUT_EXHAUSTED;
				r.slot = '0;
			end else if (!slot_used[pos]) begin
				r.outcome = hqp_pkg::OUT_EMPTY;
				r.slot = pos[hqp_pkg::SLOT_W-1:0];
				if (op == hqp_pkg::OP_INSERT) begin
					slot_key[pos] = key;
					slot_used[pos] = 1'b1;
				end
			end else begin
				r.outcome = hqp_pkg::OUT_FOUND;
				r.slot = pos[hqp_pkg::SLOT_W-1:0];
			end
			r.probe_count = cnt[hqp_pkg::COUNT_W-1:0];
			pending_q.push_back(r);
		endfunction

		function void check(logic [31:0] d);
			hqp_pkg::result_t got, exp_r;
			got = hqp_pkg::result_t'(d[hqp_pkg::RESULT_W-1:0]);
			checked++;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected result %h", d));
				return;
			end
			exp_r = pending_q.pop_front();
			if (got.outcome !== exp_r.outcome)
				report($sformatf("outcome %0d, want %0d", got.outcome, exp_r.outcome));
			if (got.slot !== exp_r.slot)
				report($sformatf("slot %0d, want %0d", got.slot, exp_r.slot));
			if (got.probe_count !== exp_r.probe_count)
				report($sformatf("probe_count %0d, want %0d",
					got.probe_count, exp_r.probe_count));
			case (exp_r.outcome)
				hqp_pkg::OUT_FOUND: n_found++;
				hqp_pkg::OUT_EMPTY: n_empty++;
				default: n_exhausted++;
			endcase
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [14:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	probe_scoreboard sb;
	int unsigned cycles;
	int unsigned sent;
	int unsigned burst_left;
	int unsigned hold_cnt;
	bit          hold_start;
	bit          hold_done;
	bit          stall_mode;
	bit [19:0]   known_keys [$];

	hash_table_quadratic_probe_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		sb = new();
		cycles = 0;
		hold_cnt = 0;
		hold_start = 1'b0;
		hold_done = 1'b0;
		stall_mode = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stalls, free-running stretches, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (hold_start) begin
				hold_cnt = 600;
				hold_start = 1'b0;
			end
			if ($urandom_range(0, 150) == 0) stall_mode = ~stall_mode;
			if (hold_cnt > 0) begin
				hold_cnt = hold_cnt - 1;
				m_tready <= 1'b0;
			end else if (stall_mode) begin
				m_tready <= ($urandom_range(0, 2) == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check(m_tdata);
	end

	task automatic wait_idle();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_size(logic [14:0] v);
		s_tvalid <= 1'b0;
		wait_idle();
		repeat (10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_size(v);
	endtask

	task automatic send(hqp_pkg::opcode_t op, bit [19:0] key);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, key, op};
		do @(posedge clk); while (!s_tready);
		sb.note(op, key);
		sent++;
		if (op == hqp_pkg::OP_INSERT) known_keys.push_back(key);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic random_phase(int unsigned sz, int unsigned n);
		bit [19:0] key;
		hqp_pkg::opcode_t op;
		int unsigned sel;
		repeat (n) begin
			op = ($urandom_range(0, 9) < 6) ? hqp_pkg::OP_INSERT : hqp_pkg::OP_SEARCH;
			sel = $urandom_range(0, 9);
			if (sel < 4 && known_keys.size() > 0)
				key = known_keys[$urandom_range(0, known_keys.size() - 1)];
			else if (sel < 8)
				key = 20'($urandom_range(0, 4 * sz + 3));
			else
				key = 20'($urandom_range(0, 20'hFFFFF));
			send(op, key);
		end
	endtask

	initial begin
		int unsigned small_sizes [15] = '{2, 3, 4, 5, 7, 8, 11, 12, 13, 17, 31, 61, 97,
			127, 251};
		int unsigned sz, pick;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		sent = 0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset size, key extremes, collision, duplicate insert
		send(hqp_pkg::OP_INSERT, 20'd0);
		send(hqp_pkg::OP_INSERT, 20'hFFFFF);
		send(hqp_pkg::OP_SEARCH, 20'hFFFFF);
		send(hqp_pkg::OP_SEARCH, 20'd5);
		send(hqp_pkg::OP_INSERT, 20'd16381);
		send(hqp_pkg::OP_INSERT, 20'd0);
		send(hqp_pkg::OP_SEARCH, 20'd16381);
		// smallest size: fill both slots then exhaust
		write_size(15'd2);
		send(hqp_pkg::OP_INSERT, 20'd6);
		send(hqp_pkg::OP_INSERT, 20'd3);
		send(hqp_pkg::OP_INSERT, 20'd9);
		send(hqp_pkg::OP_SEARCH, 20'd11);
		send(hqp_pkg::OP_SEARCH, 20'd3);
		// below range acts as 2
		write_size(15'd0);
		send(hqp_pkg::OP_SEARCH, 20'd6);
		send(hqp_pkg::OP_INSERT, 20'd8);
		// non-prime size, unreachable slots
		write_size(15'd8);
		send(hqp_pkg::OP_INSERT, 20'd1);
		send(hqp_pkg::OP_INSERT, 20'd9);
		send(hqp_pkg::OP_INSERT, 20'd17);
		send(hqp_pkg::OP_INSERT, 20'd25);
		send(hqp_pkg::OP_INSERT, 20'd33);
		send(hqp_pkg::OP_SEARCH, 20'd41);
		// above range acts as full depth
		write_size(15'h7FFF);
		send(hqp_pkg::OP_INSERT, 20'hFFFFF);
		send(hqp_pkg::OP_INSERT, 20'd16383);
		send(hqp_pkg::OP_SEARCH, 20'd32767);
		write_size(15'd16384);
		send(hqp_pkg::OP_SEARCH, 20'd16383);

		while (sent < ITEM_GOAL) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) sz = 16381;
			else if (pick == 1) sz = 16384;
			else if (pick == 2) sz = 1023;
			else sz = small_sizes[$urandom_range(0, 14)];
			write_size(sz[14:0]);
			if (sent > 600 && !hold_done) begin
				hold_start = 1'b1;
				hold_done = 1'b1;
			end
			random_phase(sz, (sz > 1000) ? $urandom_range(10, 30) : $urandom_range(30, 120));
		end
		s_tvalid <= 1'b0;

		wait_idle();
		repeat (200) @(posedge clk);
		$display("%0d requests sent, %0d results checked", sent, sb.checked);
		$display("found %0d, empty slot %0d, exhausted %0d", sb.n_found, sb.n_empty,
			sb.n_exhausted);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
